### sv/lgcg_pkg.sv
// ----------------------------------------------------------------------------
// lgcg_pkg
// Shared constants and types for the lat-lon grid central gradient block.
// ----------------------------------------------------------------------------
package lgcg_pkg;

    localparam int PHI_POINTS_DEF   = 128;
    localparam int THETA_POINTS_DEF = 64;
    localparam int SAMPLE_WIDTH_DEF = 24;

    localparam int CFG_W       = 32;
    localparam int CFG_IDX_W   = 1;
    localparam int GRAD_W      = 32;
    localparam int PHI_IDX_W   = 7;
    localparam int THETA_IDX_W = 6;
    localparam int FIFO_DEPTH  = 4;

    // 1.0 in unsigned Q8.24
    localparam logic [CFG_W-1:0] CFG_RESET = 32'h0100_0000;

    localparam logic [CFG_IDX_W-1:0] REG_INV_TWO_R_DPHI = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_INV_TWO_DY     = 1'b1;

    typedef struct packed {
        logic [GRAD_W-1:0]      grad_x;
        logic [GRAD_W-1:0]      grad_y;
        logic [PHI_IDX_W-1:0]   phi_index;
        logic [THETA_IDX_W-1:0] theta_index;
        logic                   saturated;
        logic                   last;
    } t_result;

endpackage

### sv/latlon_grid_central_gradient.sv
// ----------------------------------------------------------------------------
// latlon_grid_central_gradient
// Streaming central-difference gradient on a latitude-longitude grid.
// ----------------------------------------------------------------------------
// Samples enter on i_valid/o_ready in raster order (longitude inside each
// colatitude row); i_frame_start marks the first sample of a grid. Results
// leave on o_valid/i_ready: one per sample from row 2 on, for the point one
// row back, carrying grad_x, grad_y (signed Q16.16), its position, a clip
// flag and o_last on the final point of the grid. Scales are written on the
// i_cfg_valid/o_cfg_ready port (index 0: 1/(2 r dphi), index 1: 1/(2 dy),
// unsigned Q8.24); the user must write them only while the block is idle,
// which the block does not enforce; that port never stalls. A sample of
// rows 0 and 1 only writes the row memory. A sample with a result steps
// through idle, west, diff, mul and out: three reads of the two-read-port
// row memory and the x-scale multiply, then difference, product and round.
// A four-entry queue decouples input acceptance from the back end.
// Reset zeroes the position counters, empties the queue and output, and sets
// both scales to 1.0; the row memory is not cleared. When the receiver
// stalls, the result holds in the output register, the back end waits, the
// queue fills and o_ready drops.
// ----------------------------------------------------------------------------
module latlon_grid_central_gradient #(
    parameter int PHI_POINTS   = lgcg_pkg::PHI_POINTS_DEF,
    parameter int THETA_POINTS = lgcg_pkg::THETA_POINTS_DEF,
    parameter int SAMPLE_WIDTH = lgcg_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [SAMPLE_WIDTH-1:0]            i_sample,
    input  logic                               i_frame_start,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [lgcg_pkg::GRAD_W-1:0]        o_grad_x,
    output logic [lgcg_pkg::GRAD_W-1:0]        o_grad_y,
    output logic [lgcg_pkg::PHI_IDX_W-1:0]     o_phi_index,
    output logic [lgcg_pkg::THETA_IDX_W-1:0]   o_theta_index,
    output logic                               o_saturated,
    output logic                               o_last,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [lgcg_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [lgcg_pkg::CFG_W-1:0]         i_cfg_data
);

    localparam int ENTRY_W = SAMPLE_WIDTH + $clog2(PHI_POINTS) + $clog2(THETA_POINTS) + 3;
    localparam logic [lgcg_pkg::PHI_IDX_W-1:0] LAST_PHI_IDX =
        lgcg_pkg::PHI_IDX_W'((PHI_POINTS - 1) % 128);

    logic [lgcg_pkg::CFG_W-1:0] r_inv_two_r_dphi;
    logic [lgcg_pkg::CFG_W-1:0] r_inv_two_dy;
    logic                       w_push;
    logic [ENTRY_W-1:0]         w_push_entry;
    logic                       w_full;
    logic                       w_pop;
    logic [ENTRY_W-1:0]         w_head;
    logic                       w_empty;
    lgcg_pkg::t_result          w_result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_two_r_dphi <= lgcg_pkg::CFG_RESET;
            r_inv_two_dy     <= lgcg_pkg::CFG_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                lgcg_pkg::REG_INV_TWO_R_DPHI: r_inv_two_r_dphi <= i_cfg_data;
                lgcg_pkg::REG_INV_TWO_DY:     r_inv_two_dy     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    lgcg_front #(
        .PHI_POINTS   (PHI_POINTS),
        .THETA_POINTS (THETA_POINTS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .ENTRY_W      (ENTRY_W)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_sample      (i_sample),
        .i_frame_start (i_frame_start),
        .o_push        (w_push),
        .o_entry       (w_push_entry),
        .i_full        (w_full)
    );

    lgcg_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (lgcg_pkg::FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_entry),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_head),
        .o_empty (w_empty)
    );

    lgcg_back #(
        .PHI_POINTS   (PHI_POINTS),
        .THETA_POINTS (THETA_POINTS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .ENTRY_W      (ENTRY_W)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_entry          (w_head),
        .i_empty          (w_empty),
        .o_pop            (w_pop),
        .i_inv_two_r_dphi (r_inv_two_r_dphi),
        .i_inv_two_dy     (r_inv_two_dy),
        .o_result         (w_result),
        .o_valid          (o_valid),
        .i_ready          (i_ready)
    );

    assign o_grad_x      = w_result.grad_x;
    assign o_grad_y      = w_result.grad_y;
    assign o_phi_index   = w_result.phi_index;
    assign o_theta_index = w_result.theta_index;
    assign o_saturated   = w_result.saturated;
    assign o_last        = w_result.last;

    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_saturated |->
            (o_grad_x == 32'h7FFF_FFFF) || (o_grad_x == 32'h8000_0000) ||
            (o_grad_y == 32'h7FFF_FFFF) || (o_grad_y == 32'h8000_0000))
        else $error("saturated flag without a clipped component");

    a_last_at_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> o_phi_index == LAST_PHI_IDX)
        else $error("last flag away from the final longitude");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule

### sv/lgcg_fifo.sv
// ----------------------------------------------------------------------------
// lgcg_fifo
// Short queue between the classifying front end and the arithmetic back end.
// ----------------------------------------------------------------------------
module lgcg_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = lgcg_pkg::FIFO_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_data [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_data[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    assign n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_data[r_wr_ptr] <= i_data;
        end
    end

endmodule

### sv/lgcg_front.sv
// ----------------------------------------------------------------------------
// lgcg_front
// Accepts samples, tracks grid position and tags each one for the back end.
// ----------------------------------------------------------------------------
module lgcg_front #(
    parameter int PHI_POINTS   = lgcg_pkg::PHI_POINTS_DEF,
    parameter int THETA_POINTS = lgcg_pkg::THETA_POINTS_DEF,
    parameter int SAMPLE_WIDTH = lgcg_pkg::SAMPLE_WIDTH_DEF,
    parameter int ENTRY_W      = SAMPLE_WIDTH + $clog2(PHI_POINTS) + $clog2(THETA_POINTS) + 3
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [SAMPLE_WIDTH-1:0] i_sample,
    input  logic                    i_frame_start,
    output logic                    o_push,
    output logic [ENTRY_W-1:0]      o_entry,
    input  logic                    i_full
);

    localparam int PHI_W   = $clog2(PHI_POINTS);
    localparam int THETA_W = $clog2(THETA_POINTS);

    logic [PHI_W-1:0]   r_phi_pos;
    logic [THETA_W-1:0] r_theta_pos;
    logic [PHI_W-1:0]   n_phi_pos;
    logic [THETA_W-1:0] n_theta_pos;
    logic [PHI_W-1:0]   w_phi;
    logic [THETA_W-1:0] w_theta;
    logic               w_has_res;
    logic               w_last;
    logic [THETA_W-1:0] w_row;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    assign w_phi     = i_frame_start ? '0 : r_phi_pos;
    assign w_theta   = i_frame_start ? '0 : r_theta_pos;
    assign w_has_res = (w_theta >= THETA_W'(2));
    assign w_row     = w_theta - 1'b1;
    assign w_last    = (w_theta == THETA_W'(THETA_POINTS - 1)) &&
                       (w_phi == PHI_W'(PHI_POINTS - 1));

    assign o_entry = {i_sample, w_phi, w_theta[0], w_has_res, w_row, w_last};

    always_comb begin
        n_phi_pos   = w_phi + 1'b1;
        n_theta_pos = w_theta;
        if (w_phi == PHI_W'(PHI_POINTS - 1)) begin
            n_phi_pos = '0;
            if (w_theta == THETA_W'(THETA_POINTS - 1)) begin
                n_theta_pos = '0;
            end else begin
                n_theta_pos = w_theta + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phi_pos   <= '0;
            r_theta_pos <= '0;
        end else if (o_push) begin
            r_phi_pos   <= n_phi_pos;
            r_theta_pos <= n_theta_pos;
        end
    end

endmodule

### sv/lgcg_back.sv
// ----------------------------------------------------------------------------
// lgcg_back
// Row memory, reciprocal-sine ROM and the scaling sequencer for one result.
// ----------------------------------------------------------------------------
module lgcg_back #(
    parameter int PHI_POINTS   = lgcg_pkg::PHI_POINTS_DEF,
    parameter int THETA_POINTS = lgcg_pkg::THETA_POINTS_DEF,
    parameter int SAMPLE_WIDTH = lgcg_pkg::SAMPLE_WIDTH_DEF,
    parameter int ENTRY_W      = SAMPLE_WIDTH + $clog2(PHI_POINTS) + $clog2(THETA_POINTS) + 3
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [ENTRY_W-1:0]           i_entry,
    input  logic                         i_empty,
    output logic                         o_pop,
    input  logic [lgcg_pkg::CFG_W-1:0]   i_inv_two_r_dphi,
    input  logic [lgcg_pkg::CFG_W-1:0]   i_inv_two_dy,
    output lgcg_pkg::t_result            o_result,
    output logic                         o_valid,
    input  logic                         i_ready
);

    localparam int PHI_W     = $clog2(PHI_POINTS);
    localparam int THETA_W   = $clog2(THETA_POINTS);
    localparam int MEM_DEPTH = 2 * PHI_POINTS;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int SW        = SAMPLE_WIDTH;
    localparam int PROD_W    = SAMPLE_WIDTH + lgcg_pkg::CFG_W;
    localparam int Q_W       = PROD_W - 7;
    localparam int KP_W      = 2 * lgcg_pkg::CFG_W;
    localparam logic [63:0] PI_Q30 = 64'd3373259426;
    localparam logic [PROD_W:0] ROUND_HALF = (PROD_W + 1)'(128);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_WEST = 5'b00010,
        ST_DIFF = 5'b00100,
        ST_MUL  = 5'b01000,
        ST_OUT  = 5'b10000
    } t_state;

    // reciprocal sine per row, unsigned Q8.24
    logic [31:0] w_rsine [THETA_POINTS];

    for (genvar gj = 0; gj < THETA_POINTS; gj++) begin : g_rom
        localparam int K = (gj < THETA_POINTS - 1 - gj) ? gj : THETA_POINTS - 1 - gj;
        localparam logic [63:0] X  = (64'(K) * PI_Q30) / 64'(THETA_POINTS - 1);
        localparam logic [63:0] X2 = (X * X) >> 30;
        localparam logic [63:0] T1 = ((X  * X2) >> 30) / 64'd6;
        localparam logic [63:0] T2 = ((T1 * X2) >> 30) / 64'd20;
        localparam logic [63:0] T3 = ((T2 * X2) >> 30) / 64'd42;
        localparam logic [63:0] T4 = ((T3 * X2) >> 30) / 64'd72;
        localparam logic [63:0] T5 = ((T4 * X2) >> 30) / 64'd110;
        localparam logic [63:0] T6 = ((T5 * X2) >> 30) / 64'd156;
        localparam logic [63:0] T7 = ((T6 * X2) >> 30) / 64'd210;
        localparam logic [63:0] S  = X - T1 + T2 - T3 + T4 - T5 + T6 - T7;
        localparam logic S_POS     = ($signed(S) > 64'sd0);
        localparam logic [63:0] D  = S_POS ? S : 64'd1;
        localparam logic [63:0] R  = ((64'd1 << 54) + (D >> 1)) / D;
        localparam logic [31:0] RS = (!S_POS || (R > 64'h0000_0000_FFFF_FFFF)) ?
                                     32'hFFFF_FFFF : R[31:0];
        assign w_rsine[gj] = RS;
    end

    // queue head
    logic                   h_last;
    logic [THETA_W-1:0]     h_row;
    logic                   h_has_res;
    logic                   h_bank;
    logic [PHI_W-1:0]       h_phi;
    logic [SW-1:0]          h_sample;

    assign h_last    = i_entry[0];
    assign h_row     = i_entry[THETA_W:1];
    assign h_has_res = i_entry[THETA_W+1];
    assign h_bank    = i_entry[THETA_W+2];
    assign h_phi     = i_entry[THETA_W+2+PHI_W:THETA_W+3];
    assign h_sample  = i_entry[ENTRY_W-1 -: SW];

    t_state              r_state;
    t_state              n_state;
    logic                r_last;
    logic [THETA_W-1:0]  r_row;
    logic                r_bank;
    logic [PHI_W-1:0]    r_phi;
    logic [SW-1:0]       r_sample;
    logic [31:0]         r_rsine;
    logic [SW-1:0]       r_mem [MEM_DEPTH];
    logic [SW-1:0]       r_rd_a;
    logic [SW-1:0]       r_rd_b;
    logic [SW-1:0]       r_north;
    logic [SW-1:0]       r_east;
    logic [KP_W-1:0]     r_kprod;
    logic [31:0]         r_kx;
    logic [SW-1:0]       r_mx;
    logic [SW-1:0]       r_my;
    logic                r_nx;
    logic                r_ny;
    logic [PROD_W-1:0]   r_px;
    logic [PROD_W-1:0]   r_py;
    lgcg_pkg::t_result   r_out;
    logic                r_out_valid;

    logic                w_take;
    logic                w_load_out;
    logic [ADDR_W-1:0]   w_addr_a;
    logic [ADDR_W-1:0]   w_addr_b;
    logic [PHI_W-1:0]    w_phi_inc;
    logic [PHI_W-1:0]    w_phi_dec;
    logic [SW:0]         w_dx;
    logic [SW:0]         w_dy;
    logic [SW:0]         w_dx_mag;
    logic [SW:0]         w_dy_mag;
    logic [KP_W-24:0]    w_kx_sum;
    logic [32:0]         w_gx;
    logic [32:0]         w_gy;
    logic [PHI_W+6:0]    w_phi_ext;
    logic [THETA_W+5:0]  w_row_ext;

    function automatic logic [ADDR_W-1:0] row_addr(input logic bank,
                                                    input logic [PHI_W-1:0] phi);
        logic [ADDR_W-1:0] base;
        base = bank ? ADDR_W'(PHI_POINTS) : '0;
        return base + ADDR_W'(phi);
    endfunction

    // (prod + half) >> 8, then clip to signed Q16.16; bit 32 flags a clip
    function automatic logic [32:0] round_clip(input logic [PROD_W-1:0] prod,
                                               input logic neg);
        logic [PROD_W:0] sum;
        logic [Q_W-1:0]  q;
        logic [31:0]     mag;
        logic            sat;
        sum = {1'b0, prod} + ROUND_HALF;
        q   = sum[PROD_W:8];
        if (neg) begin
            sat = (q > Q_W'(64'h8000_0000));
            mag = sat ? 32'h8000_0000 : q[31:0];
            return {sat, ~mag + 32'd1};
        end
        sat = (q > Q_W'(64'h7FFF_FFFF));
        mag = sat ? 32'h7FFF_FFFF : q[31:0];
        return {sat, mag};
    endfunction

    assign w_take     = (r_state == ST_IDLE) && !i_empty;
    assign o_pop      = w_take;
    assign w_load_out = (r_state == ST_OUT) && (!r_out_valid || i_ready);

    assign w_phi_inc = (r_phi == PHI_W'(PHI_POINTS - 1)) ? '0 : r_phi + 1'b1;
    assign w_phi_dec = (r_phi == '0) ? PHI_W'(PHI_POINTS - 1) : r_phi - 1'b1;

    always_comb begin
        w_addr_a = row_addr(h_bank, h_phi);
        if (r_state == ST_IDLE) begin
            w_addr_b = row_addr(!h_bank,
                                (h_phi == PHI_W'(PHI_POINTS - 1)) ? '0 : h_phi + 1'b1);
        end else begin
            w_addr_b = row_addr(!r_bank, w_phi_dec);
        end
    end

    // row memory: two registered reads, one write; reads see the old data
    always_ff @(posedge i_clk) begin
        r_rd_a <= r_mem[w_addr_a];
        r_rd_b <= r_mem[w_addr_b];
        if (w_take) begin
            r_mem[w_addr_a] <= h_sample;
        end
    end

    assign w_dx     = {r_east[SW-1], r_east} - {r_rd_b[SW-1], r_rd_b};
    assign w_dy     = {r_north[SW-1], r_north} - {r_sample[SW-1], r_sample};
    assign w_dx_mag = w_dx[SW] ? (~w_dx + 1'b1) : w_dx;
    assign w_dy_mag = w_dy[SW] ? (~w_dy + 1'b1) : w_dy;
    assign w_kx_sum = {1'b0, r_kprod[KP_W-1:24]} + (KP_W - 23)'(r_kprod[23]);

    assign w_gx      = round_clip(r_px, r_nx);
    assign w_gy      = round_clip(r_py, r_ny);
    assign w_phi_ext = {7'd0, r_phi};
    assign w_row_ext = {6'd0, r_row};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_take && h_has_res) begin
                    n_state = ST_WEST;
                end
            end
            ST_WEST: n_state = ST_DIFF;
            ST_DIFF: n_state = ST_MUL;
            ST_MUL:  n_state = ST_OUT;
            ST_OUT: begin
                if (w_load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_last   <= h_last;
            r_row    <= h_row;
            r_bank   <= h_bank;
            r_phi    <= h_phi;
            r_sample <= h_sample;
            r_rsine  <= w_rsine[h_row];
        end
        if (r_state == ST_WEST) begin
            r_north <= r_rd_a;
            r_east  <= r_rd_b;
            r_kprod <= i_inv_two_r_dphi * r_rsine;
        end
        if (r_state == ST_DIFF) begin
            r_mx <= w_dx_mag[SW-1:0];
            r_nx <= w_dx[SW];
            r_my <= w_dy_mag[SW-1:0];
            r_ny <= w_dy[SW];
            r_kx <= (w_kx_sum > (KP_W - 23)'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF :
                    w_kx_sum[31:0];
        end
        if (r_state == ST_MUL) begin
            r_px <= r_mx * r_kx;
            r_py <= r_my * i_inv_two_dy;
        end
        if (w_load_out) begin
            r_out.grad_x      <= w_gx[31:0];
            r_out.grad_y      <= w_gy[31:0];
            r_out.phi_index   <= w_phi_ext[6:0];
            r_out.theta_index <= w_row_ext[5:0];
            r_out.saturated   <= w_gx[32] || w_gy[32];
            r_out.last        <= r_last;
        end
    end

    assign o_result = r_out;
    assign o_valid  = r_out_valid;

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the lat-lon grid central gradient block.
// ----------------------------------------------------------------------------
// Grid samples are queued by the stimulus process and fed by a clocked driver
// on the input handshake; a bit-accurate predictor of the gradient stencil
// runs on every accepted sample and stores any expected result. A clocked
// monitor compares every accepted result field by field. Scales are swept
// over zero, full scale and random values between phases, with several
// sender/receiver idling mixes, a long output hold-off and a final stretch
// that walks all four idling mixes in turn.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int PHI_N   = lgcg_pkg::PHI_POINTS_DEF;
    localparam int THETA_N = lgcg_pkg::THETA_POINTS_DEF;
    localparam int SW      = lgcg_pkg::SAMPLE_WIDTH_DEF;

    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] U32_MAX = 64'hFFFF_FFFF;

    localparam logic [SW-1:0] SMP_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic [SW-1:0] SMP_MIN = {1'b1, {(SW-1){1'b0}}};

    localparam int DRAIN_CYCLES   = 40;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int TIMEOUT_NS     = 4_000_000;

    typedef struct packed {
        logic [SW-1:0] sample;
        logic          frame_start;
    } t_sample_item;

    logic                                   i_clk;
    logic                                   i_rst_n       = 1'b0;
    logic                                   i_valid       = 1'b0;
    logic                                   o_ready;
    logic [SW-1:0]                          i_sample      = '0;
    logic                                   i_frame_start = 1'b0;
    logic                                   o_valid;
    logic                                   i_ready       = 1'b0;
    logic [lgcg_pkg::GRAD_W-1:0]            o_grad_x;
    logic [lgcg_pkg::GRAD_W-1:0]            o_grad_y;
    logic [lgcg_pkg::PHI_IDX_W-1:0]         o_phi_index;
    logic [lgcg_pkg::THETA_IDX_W-1:0]       o_theta_index;
    logic                                   o_saturated;
    logic                                   o_last;
    logic                                   i_cfg_valid   = 1'b0;
    logic                                   o_cfg_ready;
    logic [lgcg_pkg::CFG_IDX_W-1:0]         i_cfg_index   = '0;
    logic [lgcg_pkg::CFG_W-1:0]             i_cfg_data    = '0;

    t_sample_item        sample_q[$];
    lgcg_pkg::t_result   grad_q[$];

    // predictor state
    logic signed [SW-1:0] row_mem [0:2*PHI_N-1];
    int unsigned          pred_phi   = 0;
    int unsigned          pred_theta = 0;
    logic [31:0]          scale_dphi = lgcg_pkg::CFG_RESET;
    logic [31:0]          scale_dy   = lgcg_pkg::CFG_RESET;

    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    logic rx_hold       = 1'b0;

    int items_queued    = 0;
    int items_accepted  = 0;
    int results_checked = 0;
    int clipped_seen    = 0;
    int last_seen       = 0;
    int error_count     = 0;

    latlon_grid_central_gradient uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_sample      (i_sample),
        .i_frame_start (i_frame_start),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_grad_x      (o_grad_x),
        .o_grad_y      (o_grad_y),
        .o_phi_index   (o_phi_index),
        .o_theta_index (o_theta_index),
        .o_saturated   (o_saturated),
        .o_last        (o_last),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Timeout: %0d samples accepted, %0d results pending",
                 items_accepted, grad_q.size());
        $display("Test completed with failures");
        $finish;
    end

    // integer difference times Q8.24 scale -> Q16.16, round half away, clip
    function automatic logic [32:0] scale_q16(input longint signed diff,
                                              input logic [63:0] k);
        logic        neg;
        logic        clip;
        logic [63:0] mag;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [63:0] q;
        logic [31:0] val;
        neg  = diff < 0;
        mag  = neg ? -diff : diff;
        hi   = mag * (k >> 16);
        lo   = mag * (k & 64'hFFFF) + 64'd128;
        q    = (hi << 8) + (lo >> 8);
        clip = 1'b0;
        if (neg) begin
            if (q > 64'h8000_0000) begin
                clip = 1'b1;
                q    = 64'h8000_0000;
            end
            val = 32'd0 - q[31:0];
        end else begin
            if (q > 64'h7FFF_FFFF) begin
                clip = 1'b1;
                q    = 64'h7FFF_FFFF;
            end
            val = q[31:0];
        end
        return {clip, val};
    endfunction

    task automatic predict_gradient(input logic [SW-1:0] smp, input logic fs);
        lgcg_pkg::t_result res;
        longint signed     cur;
        longint signed     north;
        longint signed     east;
        longint signed     west;
        longint signed     sine;
        logic [63:0]       ang;
        logic [63:0]       ang2;
        logic [63:0]       term;
        logic [63:0]       recip;
        logic [63:0]       prod;
        logic [63:0]       kx;
        logic [32:0]       sx;
        logic [32:0]       sy;
        int unsigned       row;
        int unsigned       krow;
        int unsigned       n;
        int unsigned       same_base;
        int unsigned       other_base;
        cur = longint'($signed(smp));
        if (fs) begin
            pred_phi   = 0;
            pred_theta = 0;
        end
        same_base  = (pred_theta % 2) * PHI_N;
        other_base = ((pred_theta + 1) % 2) * PHI_N;
        if (pred_theta >= 2) begin
            row   = pred_theta - 1;
            north = row_mem[same_base + pred_phi];
            east  = row_mem[other_base + (pred_phi + 1) % PHI_N];
            west  = row_mem[other_base + (pred_phi + PHI_N - 1) % PHI_N];

            // reciprocal sine of the row colatitude, series to t7
            krow = (THETA_N - 1 - row < row) ? THETA_N - 1 - row : row;
            ang  = (64'(krow) * PI_Q30) / 64'(THETA_N - 1);
            ang2 = (ang * ang) >> 30;
            sine = longint'(ang);
            term = ang;
            for (n = 1; n <= 7; n++) begin
                term = ((term * ang2) >> 30) / 64'((2 * n) * (2 * n + 1));
                if (n % 2 == 1)
                    sine = sine - longint'(term);
                else
                    sine = sine + longint'(term);
            end
            if (sine <= 0) begin
                recip = U32_MAX;
            end else begin
                recip = ((64'd1 << 54) + $unsigned(sine) / 2) / $unsigned(sine);
                if (recip > U32_MAX)
                    recip = U32_MAX;
            end
            prod = 64'(scale_dphi) * recip;
            kx   = (prod >> 24) + ((prod >> 23) & 64'd1);
            if (kx > U32_MAX)
                kx = U32_MAX;

            sx = scale_q16(east - west, kx);
            sy = scale_q16(north - cur, 64'(scale_dy));
            res.grad_x      = sx[31:0];
            res.grad_y      = sy[31:0];
            res.phi_index   = lgcg_pkg::PHI_IDX_W'(pred_phi);
            res.theta_index = lgcg_pkg::THETA_IDX_W'(row);
            res.saturated   = sx[32] | sy[32];
            res.last        = (row == THETA_N - 2) && (pred_phi == PHI_N - 1);
            grad_q.push_back(res);
        end
        row_mem[same_base + pred_phi] = smp;
        pred_phi++;
        if (pred_phi >= PHI_N) begin
            pred_phi = 0;
            pred_theta++;
            if (pred_theta >= THETA_N)
                pred_theta = 0;
        end
    endtask

    // input driver
    always @(posedge i_clk) begin : drive_proc
        t_sample_item nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                predict_gradient(i_sample, i_frame_start);
                items_accepted++;
            end
            if (!i_valid || o_ready) begin
                if (sample_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    nxt = sample_q.pop_front();
                    i_valid       <= 1'b1;
                    i_sample      <= nxt.sample;
                    i_frame_start <= nxt.frame_start;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin : monitor_proc
        lgcg_pkg::t_result want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (grad_q.size() == 0) begin
                    $error("unexpected result transaction at phi %0d theta %0d",
                           o_phi_index, o_theta_index);
                    error_count++;
                end else begin
                    want = grad_q.pop_front();
                    results_checked++;
                    if (o_saturated)
                        clipped_seen++;
                    if (o_last)
                        last_seen++;
                    if (o_grad_x !== want.grad_x) begin
                        $error("grad_x: expected %0d, actual %0d",
                               $signed(want.grad_x), $signed(o_grad_x));
                        error_count++;
                    end
                    if (o_grad_y !== want.grad_y) begin
                        $error("grad_y: expected %0d, actual %0d",
                               $signed(want.grad_y), $signed(o_grad_y));
                        error_count++;
                    end
                    if (o_phi_index !== want.phi_index) begin
                        $error("phi_index: expected %0d, actual %0d",
                               want.phi_index, o_phi_index);
                        error_count++;
                    end
                    if (o_theta_index !== want.theta_index) begin
                        $error("theta_index: expected %0d, actual %0d",
                               want.theta_index, o_theta_index);
                        error_count++;
                    end
                    if (o_saturated !== want.saturated) begin
                        $error("saturated: expected %0d, actual %0d",
                               want.saturated, o_saturated);
                        error_count++;
                    end
                    if (o_last !== want.last) begin
                        $error("last: expected %0d, actual %0d", want.last, o_last);
                        error_count++;
                    end
                end
            end
            i_ready <= !rx_hold && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    function automatic logic [SW-1:0] extreme_sample(input int unsigned sel);
        case (sel)
            0:       extreme_sample = SMP_MAX;
            1:       extreme_sample = SMP_MIN;
            2:       extreme_sample = '0;
            3:       extreme_sample = '1;
            default: extreme_sample = SW'(1);
        endcase
    endfunction

    function automatic logic [SW-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0:       rand_sample = extreme_sample($urandom_range(0, 4));
            1, 2, 3: rand_sample = SW'($urandom);
            default: rand_sample = SW'($urandom_range(0, 1022) - 511);
        endcase
    endfunction

    task automatic queue_sample(input logic [SW-1:0] smp, input logic fs);
        t_sample_item item;
        item.sample      = smp;
        item.frame_start = fs;
        sample_q.push_back(item);
        items_queued++;
    endtask

    task automatic set_idle_mode(input int mode);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
            default: begin send_idle_pct = 24; recv_stall_pct = 24; end
        endcase
    endtask

    task automatic wait_idle();
        while (items_accepted != items_queued || grad_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_scale(input logic [lgcg_pkg::CFG_IDX_W-1:0] idx,
                               input logic [31:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == lgcg_pkg::REG_INV_TWO_R_DPHI)
            scale_dphi = value;
        else
            scale_dy = value;
    endtask

    initial begin : stimulus
        int          n;
        int          p;
        int          r;
        int          k;
        int          n_samples;
        int          quarter;
        logic [31:0] dphi_w;
        logic [31:0] dy_w;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // extremes at the longitude wrap edges, zero elsewhere; ends mid-row
        // and the bursts below carry on from that position
        for (n = 0; n < 3 * PHI_N + PHI_N / 2; n++) begin
            p = n % PHI_N;
            r = n / PHI_N;
            queue_sample((p < 2 || p >= PHI_N - 2) ? extreme_sample((p + r) % 5)
                                                    : SW'(0), n == 0);
        end

        for (k = 0; k < 8; k++) begin
            wait_idle();
            case (k)
                0: begin dphi_w = 32'h0000_0000; dy_w = 32'h0000_0000; end
                1: begin dphi_w = 32'hFFFF_FFFF; dy_w = 32'hFFFF_FFFF; end
                2: begin dphi_w = 32'hFFFF_FFFF; dy_w = 32'h0000_0000; end
                3: begin dphi_w = 32'h0000_0000; dy_w = 32'hFFFF_FFFF; end
                default: begin
                    dphi_w = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h0200_0000);
                    dy_w   = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h0200_0000);
                end
            endcase
            write_scale(lgcg_pkg::REG_INV_TWO_R_DPHI, dphi_w);
            write_scale(lgcg_pkg::REG_INV_TWO_DY, dy_w);
            set_idle_mode(k % 4);

            // short burst continuing the current grid, rare stray frame starts
            n_samples = $urandom_range(56, 88);
            for (n = 0; n < n_samples; n++)
                queue_sample(rand_sample(), $urandom_range(0, 599) == 0);

            if (k == 2 || k == 5) begin
                @(posedge i_clk);
                rx_hold <= 1'b1;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
                rx_hold <= 1'b0;
            end
        end

        // last stretch, idling mix changing every quarter
        wait_idle();
        write_scale(lgcg_pkg::REG_INV_TWO_R_DPHI, lgcg_pkg::CFG_RESET >> 4);
        write_scale(lgcg_pkg::REG_INV_TWO_DY, lgcg_pkg::CFG_RESET);
        n_samples = 2 * PHI_N;
        for (n = 0; n < n_samples; n++)
            queue_sample(rand_sample(), 1'b0);
        quarter = n_samples / 4;
        for (k = 0; k < 4; k++) begin
            set_idle_mode(k);
            while (sample_q.size() > (3 - k) * quarter) @(posedge i_clk);
        end
        wait_idle();

        $display("Checked %0d gradient results from %0d samples (%0d clipped, %0d end of grid)",
                 results_checked, items_accepted, clipped_seen, last_seen);
        $display("Scales swept over zero, full scale and random values under four idling mixes");
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### filelist.f
sv/lgcg_pkg.sv
sv/lgcg_fifo.sv
sv/lgcg_front.sv
sv/lgcg_back.sv
sv/latlon_grid_central_gradient.sv
verif/tb_top.sv
